// File: rtl/step_division_unit_macros.svh
// Assertion macros used by the step division unit checker.
`ifndef STEP_DIVISION_UNIT_MACROS_SVH
`define STEP_DIVISION_UNIT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define SDU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("step division unit: implication check failed");

// Next-cycle implication, masked during reset.
`define SDU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("step division unit: next-cycle check failed");

// Next-cycle implication that is also checked around reset.
`define SDU_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("step division unit: reset check failed");

`endif

// File: rtl/sdu_pkg.sv
// Types and codes shared by the step division unit.
package sdu_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned SignB  = 31;
  localparam int unsigned ActW   = 3;

  typedef enum logic [ActW-1:0] {
    ACT_LOAD  = 3'd0,
    ACT_DIV0S = 3'd1,
    ACT_DIV0U = 3'd2,
    ACT_DIV1  = 3'd3,
    ACT_DIV2S = 3'd4,
    ACT_DIV3S = 3'd5
  } action_t;

  typedef struct packed {
    logic [WordW-1:0] high_acc;
    logic [WordW-1:0] low_acc;
    logic             dividend_neg;
    logic             divisor_neg;
  } sdu_state_t;

endpackage

// File: rtl/sdu_if.sv
// Request and response channel interfaces of the step division unit.
interface sdu_req_if;
  logic                         valid;
  logic                         ready;
  logic [sdu_pkg::ActW-1:0]     action;
  logic [sdu_pkg::WordW-1:0]    operand;

  modport source (output valid, output action, output operand, input ready);
  modport sink   (input valid, input action, input operand, output ready);
endinterface

interface sdu_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sdu_pkg::WordW-1:0]    high_acc_value;
  logic [sdu_pkg::WordW-1:0]    low_acc_value;
  logic                         dividend_neg_flag;
  logic                         divisor_neg_flag;
  logic                         zero_divide;

  modport source (output valid, output high_acc_value, output low_acc_value,
                  output dividend_neg_flag, output divisor_neg_flag,
                  output zero_divide, input ready);
  modport sink   (input valid, input high_acc_value, input low_acc_value,
                  input dividend_neg_flag, input divisor_neg_flag,
                  input zero_divide, output ready);
endinterface

// File: rtl/sdu_step.sv
// Next-state logic for one division step item.
module sdu_step (
  input  sdu_pkg::sdu_state_t          cur,
  input  logic [sdu_pkg::ActW-1:0]     action,
  input  logic [sdu_pkg::WordW-1:0]    operand,
  output sdu_pkg::sdu_state_t          nxt,
  output logic                         zdiv
);

  logic [sdu_pkg::WordW-1:0] h_shift;
  logic [sdu_pkg::WordW-1:0] l_shift;
  logic [sdu_pkg::WordW:0]   sum;
  logic [sdu_pkg::WordW:0]   diff;
  logic                      take;
  logic [sdu_pkg::WordW-1:0] trial2;
  logic                      dvd_sign;

  assign h_shift  = {cur.high_acc[sdu_pkg::WordW-2:0], cur.low_acc[sdu_pkg::SignB]};
  assign l_shift  = {cur.low_acc[sdu_pkg::WordW-2:0], 1'b0};
  assign sum      = {1'b0, h_shift} + {1'b0, operand};
  assign diff     = {1'b0, h_shift} - {1'b0, operand};
  assign trial2   = cur.divisor_neg ? (cur.high_acc - operand) : (cur.high_acc + operand);
  assign dvd_sign = cur.low_acc[sdu_pkg::SignB];

  // sum[WordW] is the carry, diff[WordW] the borrow
  always_comb begin
    case ({cur.dividend_neg, cur.divisor_neg})
      2'b00:   take = !diff[sdu_pkg::WordW];
      2'b01:   take = sum[sdu_pkg::WordW];
      2'b10:   take = !sum[sdu_pkg::WordW];
      default: take = diff[sdu_pkg::WordW];
    endcase
  end

  always_comb begin
    nxt  = cur;
    zdiv = 1'b0;
    case (sdu_pkg::action_t'(action))
      sdu_pkg::ACT_LOAD: begin
        nxt.low_acc = operand;
      end
      sdu_pkg::ACT_DIV0S: begin
        if (operand == '0) begin
          zdiv = 1'b1;
        end else begin
          nxt.dividend_neg = dvd_sign;
          nxt.high_acc     = {sdu_pkg::WordW{dvd_sign}};
          nxt.divisor_neg  = operand[sdu_pkg::SignB];
        end
      end
      sdu_pkg::ACT_DIV0U: begin
        if (operand == '0) begin
          zdiv = 1'b1;
        end else begin
          nxt.high_acc     = '0;
          nxt.dividend_neg = 1'b0;
          nxt.divisor_neg  = 1'b0;
        end
      end
      sdu_pkg::ACT_DIV1: begin
        if (take) begin
          nxt.high_acc = cur.dividend_neg ^ cur.divisor_neg ? sum[sdu_pkg::WordW-1:0]
                                                            : diff[sdu_pkg::WordW-1:0];
          nxt.low_acc  = {l_shift[sdu_pkg::WordW-1:1], 1'b1};
        end else begin
          nxt.high_acc = h_shift;
          nxt.low_acc  = l_shift;
        end
      end
      sdu_pkg::ACT_DIV2S: begin
        if (cur.dividend_neg && (trial2 == '0)) begin
          nxt.high_acc = '0;
          nxt.low_acc  = cur.low_acc + sdu_pkg::WordW'(1);
        end
      end
      sdu_pkg::ACT_DIV3S: begin
        if (cur.dividend_neg != cur.divisor_neg) begin
          nxt.low_acc = '0 - cur.low_acc;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// File: rtl/step_division_unit.sv
// Step division unit: one shift-and-add/subtract division step per item, in
// the style of a CPU's div0/div1/div2/div3 step instructions. An item is
// registered on entry, stepped against the accumulator and sign flags, and
// its result lands in an output register once that register is free or read.
// One item is accepted every cycle while the response side keeps up. The
// block stalls requests only when both its input stage and output register
// hold items and the response side is not ready.
module step_division_unit (
  input  logic       clk,
  input  logic       rst,
  sdu_req_if.sink    req,
  sdu_rsp_if.source  rsp
);

  sdu_pkg::sdu_state_t         st;
  sdu_pkg::sdu_state_t         st_next;
  logic                        zdiv_next;

  logic                        s1_valid;
  logic [sdu_pkg::ActW-1:0]    s1_action;
  logic [sdu_pkg::WordW-1:0]   s1_operand;

  logic                        out_valid;
  sdu_pkg::sdu_state_t         out_state;
  logic                        out_zdiv;

  logic                        move;

  assign move      = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || move;

  sdu_step u_step (
    .cur     (st),
    .action  (s1_action),
    .operand (s1_operand),
    .nxt     (st_next),
    .zdiv    (zdiv_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (move) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_action  <= req.action;
      s1_operand <= req.operand;
    end
    if (move) begin
      out_state <= st_next;
      out_zdiv  <= zdiv_next;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.high_acc_value    = out_state.high_acc;
  assign rsp.low_acc_value     = out_state.low_acc;
  assign rsp.dividend_neg_flag = out_state.dividend_neg;
  assign rsp.divisor_neg_flag  = out_state.divisor_neg;
  assign rsp.zero_divide       = out_zdiv;

endmodule

// File: rtl/sdu_checker.sv
// Port-level checker for the step division unit, bound to the top level.
`include "step_division_unit_macros.svh"

module sdu_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [sdu_pkg::WordW-1:0]  rsp_high,
  input logic [sdu_pkg::WordW-1:0]  rsp_low
);

  `SDU_ASSERT_RST(a_rst_empty, rst, !rsp_valid)
  `SDU_ASSERT_IMPL(a_bp_only_full, !req_ready, rsp_valid && !rsp_ready)
  `SDU_ASSERT_NEXT(a_two_cycle, req_valid && req_ready, ##1 rsp_valid)
  `SDU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(rsp_high) && $stable(rsp_low))

endmodule

bind step_division_unit sdu_checker u_sdu_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_high  (rsp.high_acc_value),
  .rsp_low   (rsp.low_acc_value)
);

// File: verif/step_division_unit_tb.sv
// Self-checking testbench for the step division unit: directed table, then random division runs and random actions.
module step_division_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdu_pkg::*;

  localparam logic [ActW-1:0] ACT_NOP6 = 3'd6;
  localparam logic [ActW-1:0] ACT_NOP7 = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned LONG_HOLD = 80;

  typedef struct packed {
    logic [WordW-1:0] high;
    logic [WordW-1:0] low;
    logic             dividend_neg;
    logic             divisor_neg;
    logic             zero_div;
  } step_result_t;

  typedef struct packed {
    logic [ActW-1:0]  act;
    logic [WordW-1:0] opnd;
    logic             typed;
    step_result_t     want;
  } plan_row_t;

  localparam step_result_t NO_WANT = '0;

  logic clk = 1'b0;
  logic rst;

  sdu_req_if req_if();
  sdu_rsp_if rsp_if();

  step_division_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sdu_state_t   divider_state;
  step_result_t pending_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  result_index = 0;
  int unsigned  accepted_items;
  int unsigned  quiet_cycles = 0;
  int unsigned  idle_phase;
  int unsigned  hold_left = 0;
  bit           long_hold_done = 1'b0;

  plan_row_t directed_plan [26] = '{
    {ACT_DIV3S, 32'h1234_5678, 1'b1, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0},
    {ACT_DIV0U, 32'h0,         1'b1, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1},
    {ACT_DIV0S, 32'h0,         1'b1, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1},
    {ACT_LOAD,  32'hFFFF_FFFF, 1'b1, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
    {ACT_DIV0S, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0},
    {ACT_DIV1,  32'h8000_0000, 1'b0, NO_WANT},
    {ACT_DIV1,  32'hFFFF_FFFF, 1'b0, NO_WANT},
    {ACT_DIV1,  32'h0,         1'b0, NO_WANT},
    {ACT_DIV2S, 32'h0,         1'b0, NO_WANT},
    {ACT_DIV3S, 32'h0,         1'b0, NO_WANT},
    {ACT_NOP6,  32'hFFFF_FFFF, 1'b0, NO_WANT},
    {ACT_NOP7,  32'h0,         1'b0, NO_WANT},
    {ACT_DIV0U, 32'hFFFF_FFFF, 1'b0, NO_WANT},
    {ACT_LOAD,  32'h0,         1'b1, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0},
    {ACT_DIV0S, 32'h1,         1'b1, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0},
    {ACT_LOAD,  32'h7FFF_FFFF, 1'b1, 32'h0, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0},
    {ACT_DIV1,  32'h1,         1'b0, NO_WANT},
    {ACT_DIV1,  32'hFFFF_FFFF, 1'b0, NO_WANT},
    {ACT_LOAD,  32'h8000_0000, 1'b0, NO_WANT},
    {ACT_DIV0S, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 1'b0},
    {ACT_DIV1,  32'h7FFF_FFFF, 1'b0, NO_WANT},
    {ACT_DIV2S, 32'h7FFF_FFFF, 1'b0, NO_WANT},
    {ACT_DIV3S, 32'h0,         1'b0, NO_WANT},
    {ACT_LOAD,  32'h1,         1'b0, NO_WANT},
    {ACT_DIV0S, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h1, 1'b0, 1'b1, 1'b0},
    {ACT_DIV1,  32'hFFFF_FFFF, 1'b0, NO_WANT}
  };

  function automatic step_result_t advance_divider(logic [ActW-1:0] act,
                                                   logic [WordW-1:0] d);
    step_result_t     r;
    logic [WordW-1:0] h;
    logic [WordW-1:0] trial;
    logic             take;
    logic             zdiv;
    zdiv = 1'b0;
    case (act)
      ACT_LOAD: divider_state.low_acc = d;
      ACT_DIV0S: begin
        if (d == '0) begin
          zdiv = 1'b1;
        end else begin
          divider_state.dividend_neg = divider_state.low_acc[SignB];
          divider_state.high_acc = {WordW{divider_state.low_acc[SignB]}};
          divider_state.divisor_neg = d[SignB];
        end
      end
      ACT_DIV0U: begin
        if (d == '0) begin
          zdiv = 1'b1;
        end else begin
          divider_state.high_acc = '0;
          divider_state.dividend_neg = 1'b0;
          divider_state.divisor_neg = 1'b0;
        end
      end
      ACT_DIV1: begin
        h = {divider_state.high_acc[WordW-2:0], divider_state.low_acc[SignB]};
        divider_state.low_acc = {divider_state.low_acc[WordW-2:0], 1'b0};
        case ({divider_state.dividend_neg, divider_state.divisor_neg})
          2'b00: begin
            trial = h - d;
            take = (trial <= h);
          end
          2'b01: begin
            trial = h + d;
            take = (trial < h);
          end
          2'b10: begin
            trial = h + d;
            take = (trial >= h);
          end
          default: begin
            trial = h - d;
            take = (trial > h);
          end
        endcase
        if (take) begin
          h = trial;
          divider_state.low_acc[0] = 1'b1;
        end
        divider_state.high_acc = h;
      end
      ACT_DIV2S: begin
        if (divider_state.dividend_neg) begin
          trial = divider_state.divisor_neg ? divider_state.high_acc - d
                                            : divider_state.high_acc + d;
          if (trial == '0) begin
            divider_state.high_acc = '0;
            divider_state.low_acc = divider_state.low_acc + 1'b1;
          end
        end
      end
      ACT_DIV3S: begin
        if (divider_state.dividend_neg != divider_state.divisor_neg)
          divider_state.low_acc = '0 - divider_state.low_acc;
      end
      default: ;
    endcase
    r.high = divider_state.high_acc;
    r.low = divider_state.low_acc;
    r.dividend_neg = divider_state.dividend_neg;
    r.divisor_neg = divider_state.divisor_neg;
    r.zero_div = zdiv;
    return r;
  endfunction

  function automatic logic [WordW-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'h1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return 32'($urandom_range(255));
      6: return 32'hFFFF_FFFF - 32'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  // Drive one item and hold it until accepted; valid stays high afterwards.
  task automatic offer(logic [ActW-1:0] act, logic [WordW-1:0] opnd,
                       logic typed = 1'b0, step_result_t want = '0);
    step_result_t predicted;
    while ((idle_phase == 0 && $urandom_range(99) < 29) ||
           (idle_phase == 1 && $urandom_range(99) < 71)) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.operand <= opnd;
    do @(posedge clk); while (!req_if.ready);
    predicted = advance_divider(act, opnd);
    pending_results.push_back(typed ? want : predicted);
    accepted_items++;
  endtask

  task automatic divide_run(logic [WordW-1:0] dividend, logic [WordW-1:0] divisor,
                            bit signed_div, int unsigned steps);
    offer(ACT_LOAD, dividend);
    offer(signed_div ? ACT_DIV0S : ACT_DIV0U, divisor);
    repeat (steps) offer(ACT_DIV1, divisor);
    if (signed_div) begin
      offer(ACT_DIV2S, divisor);
      offer(ACT_DIV3S, divisor);
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off when idling stops.
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (idle_phase == 2 && !long_hold_done) begin
      rsp_if.ready <= 1'b0;
      hold_left <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (idle_phase == 0) begin
      rsp_if.ready <= ($urandom_range(99) >= 71);
    end else if (idle_phase == 1) begin
      rsp_if.ready <= ($urandom_range(99) >= 29);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    step_result_t got;
    step_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.high_acc_value, rsp_if.low_acc_value, rsp_if.dividend_neg_flag,
             rsp_if.divisor_neg_flag, rsp_if.zero_divide};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with nothing pending: %s",
                   result_index,
                   $sformatf("high=%h low=%h dn=%b dv=%b zd=%b", got.high, got.low,
                             got.dividend_neg, got.divisor_neg, got.zero_div));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: expected %s, got %s", result_index,
                     $sformatf("high=%h low=%h dn=%b dv=%b zd=%b", want.high, want.low,
                               want.dividend_neg, want.divisor_neg, want.zero_div),
                     $sformatf("high=%h low=%h dn=%b dv=%b zd=%b", got.high, got.low,
                               got.dividend_neg, got.divisor_neg, got.zero_div));
        end
      end
      result_index++;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned pick;
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.action = '0;
    req_if.operand = '0;
    divider_state = '0;
    accepted_items = 0;
    idle_phase = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i])
      offer(directed_plan[i].act, directed_plan[i].opnd, directed_plan[i].typed,
            directed_plan[i].want);

    while (accepted_items < RANDOM_ITEMS + 26) begin
      idle_phase = (accepted_items < 620) ? 0 : (accepted_items < 1170) ? 1 : 2;
      pick = $urandom_range(99);
      if (pick < 80) begin
        logic [WordW-1:0] divisor;
        divisor = pick_word();
        if (divisor == '0) divisor = 32'($urandom_range(1, 15));
        divide_run(pick_word(), divisor, 1'($urandom_range(1)), 32);
      end else if (pick < 92) begin
        // broken run: random step count from 0 to 40, divisor may be zero
        divide_run(pick_word(), pick_word(), 1'($urandom_range(1)), $urandom_range(40));
      end else begin
        repeat ($urandom_range(1, 8)) offer(3'($urandom_range(7)), pick_word());
      end
    end
    req_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sdu_pkg.sv
rtl/sdu_if.sv
rtl/sdu_step.sv
rtl/step_division_unit.sv
rtl/sdu_checker.sv
verif/step_division_unit_tb.sv
